### rtl/ppag_pkg.sv
// types and constants shared by the partition pixel address generator
// no dependencies; compiled before every other file of the block
package ppag_pkg;

	localparam int DIM_W    = 13;  // image size, stripe size, region bounds
	localparam int POS_W    = 12;  // pixel row and column
	localparam int WRK_W    = 7;   // worker count
	localparam int OWN_W    = 6;   // owner index
	localparam int OFF_W    = 26;  // rgb array offset
	localparam int STRIDE_W = 20;  // workers times stripe size
	localparam int PRE_W    = 21;  // bounds before clamping, stripe hop sums
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIM_W-1:0] MAX_DIM     = 13'd4096;
	localparam logic [WRK_W-1:0] MAX_WORKERS = 7'd64;

	// partition modes
	localparam logic [MODE_W-1:0] MODE_ROWS   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_COLS   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLOCKS = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CROWS  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CCOLS  = 3'd4;

	// request commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_PIXEL = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIPE = 3'd4;

	typedef struct packed {
		logic             cmd;
		logic [OWN_W-1:0] owner;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  pixel_row;
		logic [POS_W-1:0]  pixel_col;
		logic [OFF_W-1:0]  pixel_offset;
		logic              is_last;
	} out_t;

	// walk cursor and current region bounds
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [DIM_W-1:0] base;
		logic [DIM_W-1:0] r0;
		logic [DIM_W-1:0] r1;
		logic [DIM_W-1:0] c0;
		logic [DIM_W-1:0] c1;
	} pos_t;

	// settings latched at region start
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [DIM_W-1:0]    w;
		logic [DIM_W-1:0]    h;
		logic [DIM_W-1:0]    s;
		logic [STRIDE_W-1:0] stride;
	} walk_cfg_t;

endpackage

### rtl/ppag_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on ppag_pkg
module ppag_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [ppag_pkg::DIM_W-1:0] dividend,
	input  logic [ppag_pkg::WRK_W-1:0] divisor,
	output logic                       done,
	output logic [ppag_pkg::DIM_W-1:0] quotient,
	output logic [ppag_pkg::WRK_W-1:0] remainder
);
	import ppag_pkg::*;

	localparam int CNT_W = $clog2(DIM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIM_W-1:0] quo_q;
	logic [WRK_W-1:0] rem_q;
	logic [WRK_W-1:0] dvs_q;
	logic [WRK_W:0]   trial;
	logic [WRK_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DIM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= CNT_W'(DIM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIM_W-2:0], fits};
			rem_q <= fits ? diff[WRK_W-1:0] : trial[WRK_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/ppag_adv.sv
// next pixel of a region walk: row-major, column-major and stripe hops
// depends on ppag_pkg
module ppag_adv (
	input  ppag_pkg::pos_t      cur,
	input  ppag_pkg::walk_cfg_t cfg,
	output ppag_pkg::pos_t      nxt,
	output logic                more
);
	import ppag_pkg::*;

	logic [DIM_W-1:0] row_inc;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] hop_lim;
	logic [PRE_W-1:0] hop;
	logic [PRE_W-1:0] hop_end;
	logic [DIM_W-1:0] hop_top;
	logic             hop_ok;

	assign row_inc = {1'b0, cur.row} + DIM_W'(1);
	assign col_inc = {1'b0, cur.col} + DIM_W'(1);
	assign hop_lim = (cfg.mode == MODE_CCOLS) ? cfg.w : cfg.h;
	assign hop     = PRE_W'(cur.base) + PRE_W'(cfg.stride);
	assign hop_end = hop + PRE_W'(cfg.s);
	assign hop_ok  = hop < PRE_W'(hop_lim);
	assign hop_top = (hop_end > PRE_W'(hop_lim)) ? hop_lim : hop_end[DIM_W-1:0];

	always_comb begin
		nxt  = cur;
		more = 1'b0;
		if (cfg.mode == MODE_CCOLS) begin
			// column-major inside the stripe, then jump to the next stripe
			if (row_inc < cur.r1) begin
				nxt.row = row_inc[POS_W-1:0];
				more    = 1'b1;
			end else if (col_inc < cur.c1) begin
				nxt.col = col_inc[POS_W-1:0];
				nxt.row = cur.r0[POS_W-1:0];
				more    = 1'b1;
			end else if (hop_ok) begin
				nxt.base = hop[DIM_W-1:0];
				nxt.c0   = hop[DIM_W-1:0];
				nxt.c1   = hop_top;
				nxt.col  = hop[POS_W-1:0];
				nxt.row  = cur.r0[POS_W-1:0];
				more     = 1'b1;
			end
		end else begin
			if (col_inc < cur.c1) begin
				nxt.col = col_inc[POS_W-1:0];
				more    = 1'b1;
			end else if (row_inc < cur.r1) begin
				nxt.row = row_inc[POS_W-1:0];
				nxt.col = cur.c0[POS_W-1:0];
				more    = 1'b1;
			end else if (cfg.mode == MODE_CROWS && hop_ok) begin
				nxt.base = hop[DIM_W-1:0];
				nxt.r0   = hop[DIM_W-1:0];
				nxt.r1   = hop_top;
				nxt.row  = hop[POS_W-1:0];
				nxt.col  = cur.c0[POS_W-1:0];
				more     = 1'b1;
			end
		end
	end

endmodule

### rtl/partition_pixel_address_generator.sv
// partition pixel address generator: top level, sequencer and shared multiplier
// depends on ppag_pkg, ppag_div, ppag_adv
// next request: the row product is registered in S_OFF_MUL and the result enters the output
//   register in S_EMIT, which waits on a stalled output; new requests wait for idle
// start request: cyclic modes skip the divider, strips run the 13-step shared divider once
//   and blocks three times; out-of-range owners and exhausted walks go from idle to S_RESP,
//   and an empty region goes from S_BOUND to S_RESP instead of S_OFF_MUL and S_EMIT
// async active-low reset: configuration registers at defaults, no region active, output empty
module partition_pixel_address_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ppag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppag_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ppag_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ppag_pkg::out_t                 out_data
);
	import ppag_pkg::*;

	localparam int ST_W   = 4;
	localparam int SQ_W   = 4;   // grid side, 1 to 8
	localparam int QUO_W  = 6;   // owner / grid side
	localparam int MOD_W  = 3;   // owner mod grid side
	localparam int PROD_W = POS_W + DIM_W;

	// sequencer states
	localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
	localparam logic [ST_W-1:0] S_DIV_A   = 4'd1;  // strip height/width or block height
	localparam logic [ST_W-1:0] S_DIV_B   = 4'd2;  // block width
	localparam logic [ST_W-1:0] S_DIV_C   = 4'd3;  // owner split into grid row and column
	localparam logic [ST_W-1:0] S_MUL_S   = 4'd4;  // stripe stride
	localparam logic [ST_W-1:0] S_MUL_A   = 4'd5;  // first bound product
	localparam logic [ST_W-1:0] S_MUL_B   = 4'd6;  // block column product
	localparam logic [ST_W-1:0] S_BOUND   = 4'd7;  // clamp, empty check, load cursor
	localparam logic [ST_W-1:0] S_OFF_MUL = 4'd8;  // row times width
	localparam logic [ST_W-1:0] S_EMIT    = 4'd9;  // pixel result and cursor advance
	localparam logic [ST_W-1:0] S_RESP    = 4'd10; // status-only result

	// floor of the square root over the worker range
	function automatic logic [SQ_W-1:0] grid_side(input logic [WRK_W-1:0] p);
		if (p >= 7'd64) return 4'd8;
		if (p >= 7'd49) return 4'd7;
		if (p >= 7'd36) return 4'd6;
		if (p >= 7'd25) return 4'd5;
		if (p >= 7'd16) return 4'd4;
		if (p >= 7'd9)  return 4'd3;
		if (p >= 7'd4)  return 4'd2;
		return 4'd1;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_to(input logic [PRE_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		return (v > PRE_W'(lim)) ? lim : v[DIM_W-1:0];
	endfunction

	// configuration registers
	logic [MODE_W-1:0] part_mode_q;
	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [WRK_W-1:0]  worker_count_q;
	logic [DIM_W-1:0]  stripe_size_q;

	// settings after saturation of out-of-range values
	logic [MODE_W-1:0] mode_n;
	logic [DIM_W-1:0]  w_n;
	logic [DIM_W-1:0]  h_n;
	logic [WRK_W-1:0]  p_n;
	logic [DIM_W-1:0]  s_n;

	// sequencer and walk state
	logic [ST_W-1:0]   state_q;
	logic              walk_done_q;
	logic              div_wait_q;
	pos_t              cur_q;
	walk_cfg_t         lat_q;
	logic [WRK_W-1:0]  p_q;
	logic [SQ_W-1:0]   d_q;
	logic [OWN_W-1:0]  owner_q;
	logic [DIM_W-1:0]  u_q;
	logic [DIM_W-1:0]  bw_q;
	logic [QUO_W-1:0]  q_q;
	logic [MOD_W-1:0]  m_q;
	logic [PRE_W-1:0]  pre_r0_q;
	logic [PRE_W-1:0]  pre_r1_q;
	logic [PRE_W-1:0]  pre_c0_q;
	logic [PRE_W-1:0]  pre_c1_q;
	logic [PROD_W-1:0] prod_q;
	logic [STAT_W-1:0] stat_q;
	logic              out_valid_q;
	out_t              out_q;

	// shared divider
	logic              div_go;
	logic [DIM_W-1:0]  div_dividend;
	logic [WRK_W-1:0]  div_divisor;
	logic              div_done;
	logic [DIM_W-1:0]  div_quo;
	logic [WRK_W-1:0]  div_rem;

	// shared multiplier
	logic [POS_W-1:0]  mul_a;
	logic [DIM_W-1:0]  mul_b;

	// bound arithmetic
	logic [PRE_W-1:0]  prod_pre;
	logic [PRE_W-1:0]  sum_u;
	logic [PRE_W-1:0]  sum_s;
	logic              own_last;
	logic              blk_last_row;
	logic              blk_last_col;
	logic [PRE_W-1:0]  b_r0, b_r1, b_c0, b_c1;
	logic [PRE_W-1:0]  fin_c0, fin_c1;
	logic [DIM_W-1:0]  cl_r0, cl_r1, cl_c0, cl_c1;
	logic              region_empty;

	// emit path
	pos_t              adv_nxt;
	logic              adv_more;
	logic [PROD_W-1:0] lin_idx;
	logic [OFF_W-1:0]  offset;

	logic              in_acc;
	logic              out_free;
	logic              out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	// a result enters the output register
	assign out_load  = out_free && (state_q == S_EMIT || state_q == S_RESP);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// unused mode codes fall back to row strips, sizes saturate
	assign mode_n = (part_mode_q > MODE_CCOLS) ? MODE_ROWS : part_mode_q;
	assign w_n    = (image_width_q > MAX_DIM) ? MAX_DIM : image_width_q;
	assign h_n    = (image_height_q > MAX_DIM) ? MAX_DIM : image_height_q;
	assign p_n    = (worker_count_q == '0) ? WRK_W'(1) :
		(worker_count_q > MAX_WORKERS) ? MAX_WORKERS : worker_count_q;
	assign s_n    = (stripe_size_q == '0) ? DIM_W'(1) : stripe_size_q;

	// divider operands and issue: one go per divide state
	assign div_go = !div_wait_q &&
		(state_q == S_DIV_A || state_q == S_DIV_B || state_q == S_DIV_C);

	always_comb begin
		div_dividend = lat_q.h;
		div_divisor  = p_q;
		case (state_q)
			S_DIV_A: begin
				div_dividend = (lat_q.mode == MODE_COLS) ? lat_q.w : lat_q.h;
				div_divisor  = (lat_q.mode == MODE_BLOCKS) ? WRK_W'(d_q) : p_q;
			end
			S_DIV_B: begin
				div_dividend = lat_q.w;
				div_divisor  = WRK_W'(d_q);
			end
			S_DIV_C: begin
				div_dividend = DIM_W'(owner_q);
				div_divisor  = WRK_W'(d_q);
			end
			default: begin
				div_dividend = lat_q.h;
				div_divisor  = p_q;
			end
		endcase
	end

	ppag_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// multiplier operands, product registered every cycle
	always_comb begin
		mul_a = cur_q.row;
		mul_b = lat_q.w;
		case (state_q)
			S_MUL_S: begin
				mul_a = POS_W'(p_q);
				mul_b = lat_q.s;
			end
			S_MUL_A: begin
				mul_a = (lat_q.mode == MODE_BLOCKS) ? POS_W'(q_q) : POS_W'(owner_q);
				mul_b = (lat_q.mode inside {MODE_CROWS, MODE_CCOLS}) ? lat_q.s : u_q;
			end
			S_MUL_B: begin
				mul_a = POS_W'(m_q);
				mul_b = bw_q;
			end
			default: begin
				mul_a = cur_q.row;
				mul_b = lat_q.w;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// first bound pair from the owner product
	assign prod_pre     = PRE_W'(prod_q[STRIDE_W-1:0]);
	assign sum_u        = prod_pre + PRE_W'(u_q);
	assign sum_s        = prod_pre + PRE_W'(lat_q.s);
	assign own_last     = (WRK_W'(owner_q) + WRK_W'(1)) == p_q;
	// bottom grid row stretches to the image bottom
	assign blk_last_row = ((WRK_W+1)'(owner_q) + (WRK_W+1)'(d_q)) >= (WRK_W+1)'(p_q);
	// rightmost grid column stretches to the image edge
	assign blk_last_col = SQ_W'(m_q) == (d_q - SQ_W'(1));

	always_comb begin
		b_r0 = '0;
		b_r1 = PRE_W'(lat_q.h);
		b_c0 = '0;
		b_c1 = PRE_W'(lat_q.w);
		case (lat_q.mode)
			MODE_ROWS: begin
				b_r0 = prod_pre;
				b_r1 = own_last ? PRE_W'(lat_q.h) : sum_u;
			end
			MODE_COLS: begin
				b_c0 = prod_pre;
				b_c1 = own_last ? PRE_W'(lat_q.w) : sum_u;
			end
			MODE_BLOCKS: begin
				b_r0 = prod_pre;
				b_r1 = blk_last_row ? PRE_W'(lat_q.h) : sum_u;
			end
			MODE_CROWS: begin
				b_r0 = prod_pre;
				b_r1 = sum_s;
			end
			default: begin
				b_c0 = prod_pre;
				b_c1 = sum_s;
			end
		endcase
	end

	// block columns come from the second product
	assign fin_c0 = (lat_q.mode == MODE_BLOCKS) ? prod_pre : pre_c0_q;
	assign fin_c1 = (lat_q.mode == MODE_BLOCKS) ?
		(blk_last_col ? PRE_W'(lat_q.w) : prod_pre + PRE_W'(bw_q)) : pre_c1_q;

	assign cl_r0 = clamp_to(pre_r0_q, lat_q.h);
	assign cl_r1 = clamp_to(pre_r1_q, lat_q.h);
	assign cl_c0 = clamp_to(fin_c0, lat_q.w);
	assign cl_c1 = clamp_to(fin_c1, lat_q.w);
	assign region_empty = (cl_r0 >= cl_r1) || (cl_c0 >= cl_c1);

	// emit: offset 3 * (row * width + col), next position in parallel
	ppag_adv u_adv (
		.cur  (cur_q),
		.cfg  (lat_q),
		.nxt  (adv_nxt),
		.more (adv_more)
	);

	assign lin_idx = prod_q + PROD_W'(cur_q.col);
	assign offset  = {lin_idx, 1'b0} + OFF_W'(lin_idx);

	// control: sequencer, configuration, cursor, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			walk_done_q    <= 1'b1;
			div_wait_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			cur_q          <= '0;
			part_mode_q    <= MODE_ROWS;
			image_width_q  <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
			worker_count_q <= WRK_W'(1);
			stripe_size_q  <= DIM_W'(1);
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MODE:    part_mode_q    <= cfg_data[MODE_W-1:0];
					CFG_WIDTH:   image_width_q  <= cfg_data;
					CFG_HEIGHT:  image_height_q <= cfg_data;
					CFG_WORKERS: worker_count_q <= cfg_data[WRK_W-1:0];
					CFG_STRIPE:  stripe_size_q  <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (div_go) begin
				div_wait_q <= 1'b1;
			end else if (div_done) begin
				div_wait_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.cmd == CMD_START) begin
							walk_done_q <= 1'b1;
							if (WRK_W'(in_data.owner) >= p_n) begin
								state_q <= S_RESP;
							end else if (mode_n inside {MODE_CROWS, MODE_CCOLS}) begin
								state_q <= S_MUL_S;
							end else begin
								state_q <= S_DIV_A;
							end
						end else if (walk_done_q) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_OFF_MUL;
						end
					end
				end
				S_DIV_A: begin
					if (div_done) begin
						state_q <= (lat_q.mode == MODE_BLOCKS) ? S_DIV_B : S_MUL_S;
					end
				end
				S_DIV_B: begin
					if (div_done) begin
						state_q <= S_DIV_C;
					end
				end
				S_DIV_C: begin
					if (div_done) begin
						state_q <= S_MUL_S;
					end
				end
				S_MUL_S: state_q <= S_MUL_A;
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_BOUND;
				S_BOUND: begin
					if (region_empty) begin
						state_q <= S_RESP;
					end else begin
						cur_q.row  <= cl_r0[POS_W-1:0];
						cur_q.col  <= cl_c0[POS_W-1:0];
						cur_q.base <= (lat_q.mode == MODE_CCOLS) ? cl_c0 : cl_r0;
						cur_q.r0   <= cl_r0;
						cur_q.r1   <= cl_r1;
						cur_q.c0   <= cl_c0;
						cur_q.c1   <= cl_c1;
						state_q    <= S_OFF_MUL;
					end
				end
				S_OFF_MUL: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						walk_done_q <= !adv_more;
						if (adv_more) begin
							cur_q <= adv_nxt;
						end
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			// walk settings are taken only when a region starts
			if (in_data.cmd == CMD_START) begin
				lat_q.mode <= mode_n;
				lat_q.w    <= w_n;
				lat_q.h    <= h_n;
				lat_q.s    <= s_n;
				p_q        <= p_n;
				d_q        <= grid_side(p_n);
			end
			owner_q    <= in_data.owner;
			stat_q     <= (in_data.cmd == CMD_START) ? ST_EMPTY : ST_DONE;
		end
		if (div_done) begin
			case (state_q)
				S_DIV_A: u_q  <= div_quo;
				S_DIV_B: bw_q <= div_quo;
				S_DIV_C: begin
					q_q <= div_quo[QUO_W-1:0];
					m_q <= div_rem[MOD_W-1:0];
				end
				default: ;
			endcase
		end
		if (state_q == S_MUL_A) begin
			lat_q.stride <= prod_q[STRIDE_W-1:0];
		end
		if (state_q == S_MUL_B) begin
			pre_r0_q <= b_r0;
			pre_r1_q <= b_r1;
			pre_c0_q <= b_c0;
			pre_c1_q <= b_c1;
		end
		if (state_q == S_EMIT && out_free) begin
			out_q.status       <= ST_PIXEL;
			out_q.pixel_row    <= cur_q.row;
			out_q.pixel_col    <= cur_q.col;
			out_q.pixel_offset <= offset;
			out_q.is_last      <= !adv_more;
		end else if (state_q == S_RESP && out_free) begin
			out_q.status       <= stat_q;
			out_q.pixel_row    <= '0;
			out_q.pixel_col    <= '0;
			out_q.pixel_offset <= '0;
			out_q.is_last      <= 1'b0;
		end
	end

endmodule

### rtl/ppag_checker.sv
// port-level checks for the partition pixel address generator
// depends on ppag_pkg; bound to partition_pixel_address_generator below
module ppag_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input ppag_pkg::out_t out_data
);
	import ppag_pkg::*;

	// one request at a time: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a request is in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// status-only results carry no pixel
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_PIXEL |->
			out_data.pixel_row == '0 && out_data.pixel_col == '0 &&
			out_data.pixel_offset == '0 && !out_data.is_last)
		else $error("status-only result with pixel fields set");

endmodule

bind partition_pixel_address_generator ppag_checker u_ppag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### tb/tb.sv
// self-checking testbench for partition_pixel_address_generator
// depends on ppag_pkg and the generator rtl; predicts every result and checks it in order
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppag_pkg::*;

	localparam longint unsigned DIM_CAP    = 64'(MAX_DIM);
	localparam longint unsigned WORKER_CAP = 64'(MAX_WORKERS);
	localparam int DIRECTED_REQS = 26;
	localparam int RANDOM_REQS   = 524;
	localparam int HOLD_AFTER    = 150;  // accepted requests before the long receiver hold-off
	localparam int HOLD_CYCLES   = 300;
	localparam int WALK_CAP      = 48;   // next requests per well-formed walk at most

	// walk cursor plus the bounds of the region (or current stripe) being walked
	typedef struct {
		longint unsigned row, col, base;
		longint unsigned r0, r1, c0, c1;
	} cursor_t;

	// keeps its own copy of the registers and walk state, predicts one result per
	// accepted request and checks results against the oldest prediction
	class region_walk_tracker;
		logic [MODE_W-1:0] reg_mode, walk_mode;
		longint unsigned   reg_w, reg_h, reg_p, reg_s;
		longint unsigned   walk_w, walk_h, walk_s, walk_stride;
		cursor_t           cur;
		bit                walk_done;
		out_t              expected_pixels[$];
		int                mismatches, checked, n_pixel, n_empty, n_done;

		function new();
			reg_mode = MODE_ROWS;
			reg_w = 1;
			reg_h = 1;
			reg_p = 1;
			reg_s = 1;
			walk_mode = MODE_ROWS;
			walk_w = 1;
			walk_h = 1;
			walk_s = 1;
			walk_stride = 1;
			cur = '{default: 0};
			walk_done = 1'b1;
			mismatches = 0;
			checked = 0;
			n_pixel = 0;
			n_empty = 0;
			n_done = 0;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
			case (idx)
				CFG_MODE:    reg_mode = v[MODE_W-1:0];
				CFG_WIDTH:   reg_w = 64'(v);
				CFG_HEIGHT:  reg_h = 64'(v);
				CFG_WORKERS: reg_p = 64'(v[WRK_W-1:0]);
				CFG_STRIPE:  reg_s = 64'(v);
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// moves to the following pixel; 0 when the region has none left
		function bit step_cursor(input cursor_t p, output cursor_t q);
			longint unsigned nb;
			q = p;
			if (walk_mode == MODE_CCOLS) begin
				if (q.row + 1 < q.r1) begin
					q.row++;
					return 1'b1;
				end
				if (q.col + 1 < q.c1) begin
					q.col++;
					q.row = q.r0;
					return 1'b1;
				end
				nb = q.base + walk_stride;
				if (nb >= walk_w) return 1'b0;
				q.base = nb;
				q.c0 = nb;
				q.c1 = (nb + walk_s < walk_w) ? nb + walk_s : walk_w;
				q.col = q.c0;
				q.row = q.r0;
				return 1'b1;
			end
			if (q.col + 1 < q.c1) begin
				q.col++;
				return 1'b1;
			end
			if (q.row + 1 < q.r1) begin
				q.row++;
				q.col = q.c0;
				return 1'b1;
			end
			if (walk_mode == MODE_CROWS) begin
				nb = q.base + walk_stride;
				if (nb >= walk_h) return 1'b0;
				q.base = nb;
				q.r0 = nb;
				q.r1 = (nb + walk_s < walk_h) ? nb + walk_s : walk_h;
				q.row = q.r0;
				q.col = q.c0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function out_t status_only(input logic [STAT_W-1:0] st);
			out_t r;
			r = '0;
			r.status = st;
			return r;
		endfunction

		// current pixel, flagged last when no step is left
		function out_t pixel_result();
			cursor_t         nx;
			bit              more;
			longint unsigned off;
			out_t            r;
			more = step_cursor(cur, nx);
			off = 64'd3 * (cur.row * walk_w + cur.col);
			r.status = ST_PIXEL;
			r.pixel_row = POS_W'(cur.row);
			r.pixel_col = POS_W'(cur.col);
			r.pixel_offset = OFF_W'(off);
			r.is_last = !more;
			if (!more) walk_done = 1'b1;
			return r;
		endfunction

		function out_t start_region(input longint unsigned who);
			longint unsigned wd, ht, np, ss, span, d, bw, bh, r0, r1, c0, c1;
			wd = (reg_w > DIM_CAP) ? DIM_CAP : reg_w;
			ht = (reg_h > DIM_CAP) ? DIM_CAP : reg_h;
			np = (reg_p == 0) ? 1 : reg_p;
			if (np > WORKER_CAP) np = WORKER_CAP;
			ss = (reg_s == 0) ? 1 : reg_s;
			r0 = 0;
			r1 = ht;
			c0 = 0;
			c1 = wd;
			// settings are latched here and hold for the whole walk
			walk_mode = (reg_mode > MODE_CCOLS) ? MODE_ROWS : reg_mode;
			walk_w = wd;
			walk_h = ht;
			walk_s = ss;
			walk_stride = np * ss;
			walk_done = 1'b1;
			if (who >= np) return status_only(ST_EMPTY);
			case (walk_mode)
				MODE_ROWS: begin
					span = ht / np;
					r0 = who * span;
					r1 = (who + 1 == np) ? ht : (who + 1) * span;
				end
				MODE_COLS: begin
					span = wd / np;
					c0 = who * span;
					c1 = (who + 1 == np) ? wd : (who + 1) * span;
				end
				MODE_BLOCKS: begin
					d = 1;
					while ((d + 1) * (d + 1) <= np) d++;
					bw = wd / d;
					bh = ht / d;
					r0 = (who / d) * bh;
					r1 = (who / d + 1) * bh;
					c0 = (who % d) * bw;
					c1 = (who % d + 1) * bw;
					if ((who + 1) % d == 0) c1 = wd;
					if (who + d >= np) r1 = ht;
				end
				MODE_CROWS: begin
					r0 = who * ss;
					r1 = r0 + ss;
				end
				default: begin
					c0 = who * ss;
					c1 = c0 + ss;
				end
			endcase
			if (r0 > ht) r0 = ht;
			if (r1 > ht) r1 = ht;
			if (c0 > wd) c0 = wd;
			if (c1 > wd) c1 = wd;
			if (r0 >= r1 || c0 >= c1) return status_only(ST_EMPTY);
			cur.r0 = r0;
			cur.r1 = r1;
			cur.c0 = c0;
			cur.c1 = c1;
			cur.base = (walk_mode == MODE_CCOLS) ? c0 : r0;
			cur.row = r0;
			cur.col = c0;
			walk_done = 1'b0;
			return pixel_result();
		endfunction

		function void note_request(input in_t r);
			cursor_t nx;
			if (r.cmd == CMD_START) begin
				expected_pixels.push_back(start_region(64'(r.owner)));
			end else if (!walk_done && step_cursor(cur, nx)) begin
				cur = nx;
				expected_pixels.push_back(pixel_result());
			end else begin
				walk_done = 1'b1;
				expected_pixels.push_back(status_only(ST_DONE));
			end
		endfunction

		function void check_result(input out_t got);
			out_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result st=%0d row=%0d col=%0d off=%0d last=%0d",
						$time, got.status, got.pixel_row, got.pixel_col,
						got.pixel_offset, got.is_last);
				return;
			end
			want = expected_pixels.pop_front();
			checked++;
			case (want.status)
				ST_PIXEL: n_pixel++;
				ST_EMPTY: n_empty++;
				default:  n_done++;
			endcase
			if (got.status !== want.status || got.pixel_row !== want.pixel_row ||
			    got.pixel_col !== want.pixel_col || got.pixel_offset !== want.pixel_offset ||
			    got.is_last !== want.is_last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("%0t: result %0d expected st=%0d row=%0d col=%0d off=%0d last=%0d,",
						$time, checked, want.status, want.pixel_row, want.pixel_col,
						want.pixel_offset, want.is_last);
					$display(" got st=%0d row=%0d col=%0d off=%0d last=%0d",
						got.status, got.pixel_row, got.pixel_col,
						got.pixel_offset, got.is_last);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 in_valid, in_ready;
	in_t                  in_data;
	logic                 out_valid, out_ready;
	out_t                 out_data;

	region_walk_tracker sb;
	int accepted_cnt;  // requests accepted so far
	int burst_left;    // requests left in the current sender burst
	int cfg_writes;

	partition_pixel_address_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// offer one request and hold it until accepted; bursts of random length are
	// separated by random gaps, and a gap of zero keeps valid high without a dip
	task automatic send_req(input logic cmd, input logic [OWN_W-1:0] who);
		in_t d;
		int  gap;
		d.cmd = cmd;
		d.owner = who;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(d);
		accepted_cnt++;
	endtask

	// stop offering and let every predicted result come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, DIM_W'(val));
		cfg_writes++;
	endtask

	// register writes only once the block is idle; sel picks which ones are written
	task automatic configure(input int unsigned m, w, h, p, s, input logic [4:0] sel);
		wait_drained();
		if (sel[0]) write_setting(CFG_MODE, m);
		if (sel[1]) write_setting(CFG_WIDTH, w);
		if (sel[2]) write_setting(CFG_HEIGHT, h);
		if (sel[3]) write_setting(CFG_WORKERS, p);
		if (sel[4]) write_setting(CFG_STRIPE, s);
		cfg_valid <= 1'b0;
	endtask

	// start a region, follow it with next requests until the tracker says it is
	// exhausted or cap is reached, then optionally one request past the end
	task automatic walk_region(input logic [OWN_W-1:0] who, input int cap, input bit overrun);
		int steps;
		steps = 0;
		send_req(CMD_START, who);
		while (!sb.walk_done && steps < cap) begin
			send_req(CMD_NEXT, OWN_W'($urandom_range(0, 63)));
			steps++;
		end
		if (overrun) send_req(CMD_NEXT, OWN_W'($urandom_range(0, 63)));
	endtask

	// image sizes: mostly tiny, with zero, the cap, above the cap and anything at all
	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return 4096;
			2: return 8191;
			3: return $urandom_range(0, 8191);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	task automatic random_phase();
		int unsigned      m, w, h, p, s, kind, np;
		logic [4:0]       sel;
		logic [OWN_W-1:0] who;
		m = $urandom_range(0, 9);
		if (m > 4) m = (m == 9) ? $urandom_range(5, 7) : m - 5;  // unused modes now and then
		w = pick_dim();
		h = pick_dim();
		case ($urandom_range(0, 11))
			0: p = 0;
			1: p = 64;
			2: p = 127;
			3: p = $urandom_range(0, 127);
			default: p = $urandom_range(1, 9);
		endcase
		case ($urandom_range(0, 7))
			0: s = 0;
			1: s = 8191;
			2: s = $urandom_range(1, 4096);
			default: s = $urandom_range(1, 3);
		endcase
		sel = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'b11111;
		configure(m, w, h, p, s, sel);
		// a walk left unfinished by the last phase may still be stepped after the settings change
		repeat ($urandom_range(1, 4)) begin
			np = (sb.reg_p == 0) ? 1 : ((sb.reg_p > WORKER_CAP) ? 64 : int'(sb.reg_p));
			who = ($urandom_range(0, 7) == 0) ? OWN_W'($urandom_range(0, 63)) :
				OWN_W'($urandom_range(0, np - 1));
			kind = $urandom_range(0, 9);
			if (kind == 0)
				send_req(1'($urandom_range(0, 1)), OWN_W'($urandom_range(0, 63)));
			else if (kind == 1)
				walk_region(who, $urandom_range(0, 3), 1'b0);
			else
				walk_region(who, WALK_CAP, $urandom_range(0, 1) == 1);
		end
	endtask

	// result side: every accepted result goes to the tracker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// receiver stall patterns, switched at random, plus one long
	// hold-off while the sender keeps offering so the block backs up into its input
	initial begin : result_sink
		int hold_left, span_left, pattern, tick;
		bit held;
		hold_left = 0;
		span_left = 0;
		pattern = 0;
		tick = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (!held && accepted_cnt >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (span_left == 0) begin
					pattern = $urandom_range(0, 3);
					span_left = $urandom_range(16, 96);
				end
				span_left--;
				case (pattern)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= (tick % 4 == 0);
					default: out_ready <= (tick % 7 < 5);
				endcase
			end
		end
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		sb = new();
		accepted_cnt = 0;
		burst_left = 0;
		cfg_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: next with nothing active, one-pixel image, owner out of range
		send_req(CMD_NEXT, '0);
		walk_region('0, 4, 1'b1);
		send_req(CMD_START, 6'd63);

		// unused mode acts as rows, zero workers and zero stripe act as one
		configure(7, 3, 2, 0, 0, 5'b11111);
		walk_region('0, 10, 1'b1);

		// blocks with a non-square worker count: bottom blocks stretch to the image bottom
		configure(MODE_BLOCKS, 2, 3, 5, 1, 5'b11111);
		walk_region(6'd3, 5, 1'b0);
		send_req(CMD_START, 6'd4);

		// cyclic columns walk column-major, hopping by workers times stripe
		configure(MODE_CCOLS, 5, 2, 2, 1, 5'b11111);
		walk_region(6'd1, 8, 1'b0);

		// cyclic rows, a single stripe that ends before the image bottom, then past the end
		configure(MODE_CROWS, 2, 5, 2, 2, 5'b11111);
		walk_region(6'd1, 8, 1'b1);

		// oversized width saturates, zero height leaves nothing, worker count saturates
		configure(MODE_BLOCKS, 8191, 0, 127, 8191, 5'b11111);
		send_req(CMD_START, '0);

		// largest image: stripe of the last worker lands on the last row
		configure(MODE_CROWS, 4096, 4096, 64, 65, 5'b11111);
		walk_region(6'd63, 1, 1'b0);

		while (accepted_cnt < DIRECTED_REQS + RANDOM_REQS) random_phase();

		wait_drained();
		repeat (20) @(posedge clk);  // anything extra the block still emits gets flagged

		$display("run covered %0d requests under %0d register writes, %0d results checked",
			accepted_cnt, cfg_writes, sb.checked);
		$display("results seen: %0d pixels, %0d empty regions, %0d past the end",
			sb.n_pixel, sb.n_empty, sb.n_done);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### files.f
rtl/ppag_pkg.sv
rtl/ppag_div.sv
rtl/ppag_adv.sv
rtl/partition_pixel_address_generator.sv
rtl/ppag_checker.sv
tb/tb.sv
